FILE: src/slps_pkg.sv
`default_nettype none
package slps_pkg;

    // System mode codes as carried on the input beat
    typedef enum logic [3:0] {
        MODE_UNINIT     = 4'd0,
        MODE_INIT       = 4'd1,
        MODE_STANDBY    = 4'd2,
        MODE_PREARM     = 4'd3,
        MODE_ARMED      = 4'd4,
        MODE_IN_AIR     = 4'd5,
        MODE_FAILSAFE   = 4'd6,
        MODE_TERMINATED = 4'd7,
        MODE_CALIB      = 4'd8
    } t_mode;

    localparam logic [1:0] PIN_BLUE  = 2'd0;
    localparam logic [1:0] PIN_GREEN = 2'd1;
    localparam logic [1:0] PIN_RED   = 2'd2;
    localparam logic [1:0] PIN_BUZZ  = 2'd3;

    localparam int unsigned PERIOD_BITS  = 32;
    localparam logic [PERIOD_BITS-1:0] MIN_PERIOD   = 32'd250;
    localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = 32'd500;

    // Pattern state, tick bookkeeping excluded
    typedef struct packed {
        logic [3:0] levels;
        logic [3:0] toggles;
        logic [3:0] prev_mode;
        logic       beep_pending;
        logic       buzz_phase;
    } t_pat_state;

endpackage
`default_nettype wire

FILE: src/slps_in_if.sv
`default_nettype none
interface slps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] tick_now;
    logic [3:0]  system_mode;
    logic        clock_fault;
    logic        sd_fault;

    modport source (output valid, tick_now, system_mode, clock_fault, sd_fault,
                    input ready);
    modport sink   (input valid, tick_now, system_mode, clock_fault, sd_fault,
                    output ready);
endinterface
`default_nettype wire

FILE: src/slps_out_if.sv
`default_nettype none
interface slps_out_if;
    logic valid;
    logic ready;
    logic blue_level;
    logic green_level;
    logic red_level;
    logic buzzer_level;
    logic pattern_updated;
    logic start_beep;

    modport source (output valid, blue_level, green_level, red_level, buzzer_level,
                    pattern_updated, start_beep, input ready);
    modport sink   (input valid, blue_level, green_level, red_level, buzzer_level,
                    pattern_updated, start_beep, output ready);
endinterface
`default_nettype wire

FILE: src/slps_cfg_if.sv
`default_nettype none
interface slps_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: src/slps_step.sv
`default_nettype none
module slps_step (
    input  wire slps_pkg::t_pat_state i_st,
    input  wire                       i_update,
    input  wire logic [3:0]           i_mode,
    input  wire                       i_clock_fault,
    input  wire                       i_sd_fault,
    output slps_pkg::t_pat_state      o_st,
    output logic                      o_beep
);

    function automatic slps_pkg::t_pat_state flip(slps_pkg::t_pat_state s,
                                                  logic [1:0] pin);
        slps_pkg::t_pat_state r;
        r = s;
        r.toggles[pin] = ~s.toggles[pin];
        r.levels[pin]  = ~s.toggles[pin];
        return r;
    endfunction

    always_comb begin
        o_st   = i_st;
        o_beep = 1'b0;
        if (i_update) begin
            // mode change drops the three LEDs, buzzer untouched
            if (i_mode != i_st.prev_mode) begin
                o_st.levels[2:0]  = 3'b000;
                o_st.toggles[2:0] = 3'b000;
                o_st.prev_mode    = i_mode;
            end
            case (i_mode)
                slps_pkg::MODE_INIT: begin
                    if (o_st.beep_pending) begin
                        o_st.beep_pending = 1'b0;
                        o_beep = 1'b1;
                        o_st.levels[slps_pkg::PIN_BUZZ] = 1'b0;
                    end
                    o_st = flip(o_st, slps_pkg::PIN_BLUE);
                end
                slps_pkg::MODE_STANDBY: begin
                    o_st = flip(o_st, slps_pkg::PIN_GREEN);
                end
                slps_pkg::MODE_PREARM: begin
                    o_st = flip(o_st, slps_pkg::PIN_GREEN);
                    o_st = flip(o_st, slps_pkg::PIN_BLUE);
                end
                slps_pkg::MODE_ARMED: begin
                    o_st = flip(o_st, slps_pkg::PIN_GREEN);
                    o_st.levels[slps_pkg::PIN_RED] = 1'b1;
                end
                slps_pkg::MODE_IN_AIR: begin
                    o_st = flip(o_st, slps_pkg::PIN_GREEN);
                    o_st = flip(o_st, slps_pkg::PIN_RED);
                end
                slps_pkg::MODE_FAILSAFE: begin
                    o_st = flip(o_st, slps_pkg::PIN_RED);
                    o_st.buzz_phase = ~o_st.buzz_phase;
                    // buzzer flips every second failsafe update
                    if (!o_st.buzz_phase) begin
                        o_st = flip(o_st, slps_pkg::PIN_BUZZ);
                    end
                    o_st.levels[slps_pkg::PIN_BLUE]  = i_clock_fault;
                    o_st.levels[slps_pkg::PIN_GREEN] = i_sd_fault;
                end
                slps_pkg::MODE_TERMINATED: begin
                    o_st.levels[slps_pkg::PIN_RED]  = 1'b1;
                    o_st.levels[slps_pkg::PIN_BUZZ] = 1'b1;
                end
                slps_pkg::MODE_CALIB: begin
                    o_st = flip(o_st, slps_pkg::PIN_BLUE);
                    o_st = flip(o_st, slps_pkg::PIN_GREEN);
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/status_led_pattern_sequencer.sv
// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the output register frees itself in the
// same cycle its beat is taken, so input ready only drops on a held result.
// Reset (i_rst_n low, synchronous): period 500, last update tick 0, mode
// uninit, all pins and toggle bits low, init beep armed, output empty.
`default_nettype none
module status_led_pattern_sequencer #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    slps_in_if.sink    i_in,
    slps_cfg_if.sink   i_cfg,
    slps_out_if.source o_out
);

    logic [slps_pkg::PERIOD_BITS-1:0] r_period;
    logic [TICK_BITS-1:0]             r_last_tick;
    slps_pkg::t_pat_state             r_st;
    slps_pkg::t_pat_state             n_st;
    logic                             n_beep;

    logic       r_out_valid;
    logic [3:0] r_out_levels;
    logic       r_out_updated;
    logic       r_out_beep;

    logic [TICK_BITS-1:0] now_ext;
    logic [TICK_BITS-1:0] elapsed;
    logic                 do_update;
    logic                 in_fire;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;

    assign now_ext   = TICK_BITS'(64'(i_in.tick_now));
    assign elapsed   = now_ext - r_last_tick;
    assign do_update = 64'(elapsed) >= 64'(r_period);

    slps_step u_step (
        .i_st          (r_st),
        .i_update      (do_update),
        .i_mode        (i_in.system_mode),
        .i_clock_fault (i_in.clock_fault),
        .i_sd_fault    (i_in.sd_fault),
        .o_st          (n_st),
        .o_beep        (n_beep)
    );

    // period clamp is applied when written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= slps_pkg::RESET_PERIOD;
        end else if (i_cfg.valid) begin
            r_period <= (i_cfg.data < slps_pkg::MIN_PERIOD) ? slps_pkg::MIN_PERIOD
                                                            : i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tick          <= '0;
            r_st.levels          <= 4'b0000;
            r_st.toggles         <= 4'b0000;
            r_st.prev_mode       <= slps_pkg::MODE_UNINIT;
            r_st.beep_pending    <= 1'b1;
            r_st.buzz_phase      <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (in_fire) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
                if (do_update) begin
                    r_last_tick <= now_ext;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_levels  <= n_st.levels;
            r_out_updated <= do_update;
            r_out_beep    <= n_beep;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.blue_level      = r_out_levels[slps_pkg::PIN_BLUE];
    assign o_out.green_level     = r_out_levels[slps_pkg::PIN_GREEN];
    assign o_out.red_level       = r_out_levels[slps_pkg::PIN_RED];
    assign o_out.buzzer_level    = r_out_levels[slps_pkg::PIN_BUZZ];
    assign o_out.pattern_updated = r_out_updated;
    assign o_out.start_beep      = r_out_beep;

`ifndef SYNTHESIS
    a_beep_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.start_beep |-> o_out.pattern_updated && !o_out.buzzer_level)
        else $error("start_beep without an applied pattern step");

    a_beep_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.beep_pending |=> !r_st.beep_pending)
        else $error("init beep re-armed outside reset");

    a_idle_keeps_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && in_fire && !do_update |=> r_st == $past(r_st))
        else $error("pattern state moved without an update");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_out_valid && !o_out.ready)
        else $error("input stalled while output register free");
`endif

endmodule
`default_nettype wire

FILE: tb/status_led_pattern_sequencer_test.sv
`timescale 1ns / 100ps
module status_led_pattern_sequencer_test;

    localparam logic [3:0] MODE_IDLE_LO = 4'd9;
    localparam logic [3:0] MODE_IDLE_HI = 4'd15;

    typedef struct packed {
        logic blue;
        logic green;
        logic red;
        logic buzz;
        logic updated;
        logic beep;
    } t_pin_result;

    class led_pattern_scoreboard;
        logic [31:0]          period_reg;
        logic [31:0]          last_tick;
        slps_pkg::t_pat_state pat;
        t_pin_result          expected_levels[$];
        int unsigned          mismatches;

        function new();
            period_reg = slps_pkg::RESET_PERIOD;
            last_tick  = '0;
            pat        = '0;
            pat.beep_pending = 1'b1;
            mismatches = 0;
        endfunction

        function logic [31:0] eff_period();
            return (period_reg < slps_pkg::MIN_PERIOD) ? slps_pkg::MIN_PERIOD : period_reg;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void set_period(logic [31:0] value);
            period_reg = value;
        endfunction

        function void toggle_pin(logic [1:0] pin);
            pat.toggles[pin] = ~pat.toggles[pin];
            pat.levels[pin]  = pat.toggles[pin];
        endfunction

        // next pin levels for one accepted sample
        function void note_sample(logic [31:0] tick, logic [3:0] mode, logic cf, logic sf);
            t_pin_result r;
            logic [31:0] elapsed;
            r = '0;
            elapsed = tick - last_tick;
            if (elapsed >= eff_period()) begin
                r.updated = 1'b1;
                last_tick = tick;
                if (mode != pat.prev_mode) begin
                    pat.levels[2:0]  = '0;
                    pat.toggles[2:0] = '0;
                    pat.prev_mode    = mode;
                end
                case (mode)
                    slps_pkg::MODE_INIT: begin
                        if (pat.beep_pending) begin
                            pat.beep_pending = 1'b0;
                            r.beep = 1'b1;
                            pat.levels[slps_pkg::PIN_BUZZ] = 1'b0;
                        end
                        toggle_pin(slps_pkg::PIN_BLUE);
                    end
                    slps_pkg::MODE_STANDBY: toggle_pin(slps_pkg::PIN_GREEN);
                    slps_pkg::MODE_PREARM: begin
                        toggle_pin(slps_pkg::PIN_GREEN);
                        toggle_pin(slps_pkg::PIN_BLUE);
                    end
                    slps_pkg::MODE_ARMED: begin
                        toggle_pin(slps_pkg::PIN_GREEN);
                        pat.levels[slps_pkg::PIN_RED] = 1'b1;
                    end
                    slps_pkg::MODE_IN_AIR: begin
                        toggle_pin(slps_pkg::PIN_GREEN);
                        toggle_pin(slps_pkg::PIN_RED);
                    end
                    slps_pkg::MODE_FAILSAFE: begin
                        toggle_pin(slps_pkg::PIN_RED);
                        pat.buzz_phase = ~pat.buzz_phase;
                        if (!pat.buzz_phase) toggle_pin(slps_pkg::PIN_BUZZ);
                        pat.levels[slps_pkg::PIN_BLUE]  = cf;
                        pat.levels[slps_pkg::PIN_GREEN] = sf;
                    end
                    slps_pkg::MODE_TERMINATED: begin
                        pat.levels[slps_pkg::PIN_RED]  = 1'b1;
                        pat.levels[slps_pkg::PIN_BUZZ] = 1'b1;
                    end
                    slps_pkg::MODE_CALIB: begin
                        toggle_pin(slps_pkg::PIN_BLUE);
                        toggle_pin(slps_pkg::PIN_GREEN);
                    end
                    default: ;
                endcase
            end
            r.blue  = pat.levels[slps_pkg::PIN_BLUE];
            r.green = pat.levels[slps_pkg::PIN_GREEN];
            r.red   = pat.levels[slps_pkg::PIN_RED];
            r.buzz  = pat.levels[slps_pkg::PIN_BUZZ];
            expected_levels.push_back(r);
        endfunction

        function void check_result(t_pin_result got);
            t_pin_result want;
            if (expected_levels.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result beat with nothing expected:", $time,
                             " b%0b g%0b r%0b z%0b u%0b s%0b",
                             got.blue, got.green, got.red, got.buzz, got.updated,
                             got.beep);
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            if (got !== want) begin
                if (mismatches < 10)
                    $display("%0t: mismatch exp b%0b g%0b r%0b z%0b u%0b s%0b,",
                             $time, want.blue, want.green, want.red, want.buzz,
                             want.updated, want.beep,
                             " got b%0b g%0b r%0b z%0b u%0b s%0b",
                             got.blue, got.green, got.red, got.buzz, got.updated,
                             got.beep);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    slps_in_if  in_bus();
    slps_cfg_if cfg_bus();
    slps_out_if out_bus();

    status_led_pattern_sequencer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    led_pattern_scoreboard sb;
    int  recv_stall;
    bit  recv_quiet;
    bit  send_quiet;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("status_led_pattern_sequencer_test: done, errors");
        $finish;
    end

    // result side: draw a stall per beat, quiet stretches now and then
    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_result('{out_bus.blue_level, out_bus.green_level, out_bus.red_level,
                              out_bus.buzzer_level, out_bus.pattern_updated,
                              out_bus.start_beep});
            if ($urandom_range(0, 29) == 0) recv_quiet = ~recv_quiet;
            recv_stall = recv_quiet ? 0 : $urandom_range(0, 8);
        end
    end

    always @(negedge clk) begin
        if (recv_stall > 0) begin
            out_bus.ready = 1'b0;
            recv_stall--;
        end else begin
            out_bus.ready = 1'b1;
        end
    end

    task automatic send_item(logic [31:0] tick, logic [3:0] mode, logic cf, logic sf);
        int gap;
        if ($urandom_range(0, 29) == 0) send_quiet = ~send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_bus.tick_now    = tick;
        in_bus.system_mode = mode;
        in_bus.clock_fault = cf;
        in_bus.sd_fault    = sf;
        in_bus.valid       = 1'b1;
        do @(posedge clk); while (!in_bus.ready);
        sb.note_sample(tick, mode, cf, sf);
        @(negedge clk);
    endtask

    // tick lands exactly one period after the last update
    task automatic send_step(logic [3:0] mode, logic cf = 1'b0, logic sf = 1'b0);
        send_item(sb.last_tick + sb.eff_period(), mode, cf, sf);
    endtask

    task automatic wait_all_results();
        in_bus.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_period(logic [31:0] value);
        cfg_bus.data  = value;
        cfg_bus.valid = 1'b1;
        do @(posedge clk); while (!cfg_bus.ready);
        sb.set_period(value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic run_directed();
        send_item(32'd0, slps_pkg::MODE_UNINIT, 1'b0, 1'b0);
        // one short of the period
        send_item(32'd499, slps_pkg::MODE_INIT, 1'b0, 1'b0);
        // first init update: beep
        send_item(32'd500, slps_pkg::MODE_INIT, 1'b0, 1'b0);
        send_step(slps_pkg::MODE_INIT);
        send_step(slps_pkg::MODE_STANDBY);
        send_step(slps_pkg::MODE_STANDBY);
        send_step(slps_pkg::MODE_PREARM);
        send_step(slps_pkg::MODE_PREARM);
        send_step(slps_pkg::MODE_ARMED);
        send_step(slps_pkg::MODE_ARMED);
        send_step(slps_pkg::MODE_IN_AIR);
        send_step(slps_pkg::MODE_IN_AIR);
        send_step(slps_pkg::MODE_FAILSAFE, 1'b1, 1'b0);
        send_step(slps_pkg::MODE_FAILSAFE, 1'b0, 1'b1);
        send_step(slps_pkg::MODE_FAILSAFE, 1'b1, 1'b1);
        send_step(slps_pkg::MODE_FAILSAFE, 1'b0, 1'b0);
        send_step(slps_pkg::MODE_TERMINATED);
        // buzzer survives the change
        send_step(slps_pkg::MODE_CALIB);
        send_step(slps_pkg::MODE_CALIB);
        send_step(MODE_IDLE_LO);
        send_step(MODE_IDLE_HI);
        // no second beep
        send_step(slps_pkg::MODE_INIT);
        send_item(32'hFFFF_FF00, slps_pkg::MODE_FAILSAFE, 1'b1, 1'b1);
        // elapsed across the wrap
        send_item(32'h0000_0100, slps_pkg::MODE_FAILSAFE, 1'b0, 1'b1);
        send_item(32'h0000_0101, slps_pkg::MODE_FAILSAFE, 1'b1, 1'b0);
    endtask

    task automatic run_random(int count);
        logic [31:0] p;
        logic [31:0] delta;
        logic [31:0] tick;
        logic [3:0]  mode;
        int          hold;
        int          k;
        int          pick;
        hold = 0;
        mode = slps_pkg::MODE_UNINIT;
        for (int i = 0; i < count; i++) begin
            if (hold == 0) begin
                mode = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                   : 4'($urandom_range(0, 8));
                hold = $urandom_range(1, 10);
            end
            hold--;
            p = sb.eff_period();
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                k = $urandom_range(0, 3);
                delta = (p > 32'hFFFF_FFFF - k) ? p : p + k;
            end else if (pick <= 7) begin
                delta = $urandom_range(0, p - 1);
            end else begin
                delta = $urandom_range(0, 1) ? p : p - 1;
            end
            tick = (pick == 9 && $urandom_range(0, 1)) ? $urandom : sb.last_tick + delta;
            send_item(tick, mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 149) == 0) wait_all_results();
        end
    endtask

    initial begin
        logic [31:0] periods [8];
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.tick_now = '0;
        in_bus.system_mode = slps_pkg::MODE_UNINIT;
        in_bus.clock_fault = 1'b0;
        in_bus.sd_fault = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        out_bus.ready = 1'b0;
        recv_stall = 0;
        recv_quiet = 1'b0;
        send_quiet = 1'b0;
        sb = new();
        periods = '{slps_pkg::RESET_PERIOD, 32'd0, 32'd250, 32'd249, 32'd1000,
                    32'hFFFF_FFFF, 32'd251, 32'h0};
        periods[7] = $urandom;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (int ph = 0; ph < 8; ph++) begin
            wait_all_results();
            if (ph != 0) write_period(periods[ph]);
            run_random(150);
        end
        wait_all_results();
        repeat (10) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status_led_pattern_sequencer_test: done, clean");
        else
            $display("status_led_pattern_sequencer_test: done, errors");
        $finish;
    end

endmodule
